@@ rtl/hcp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite curve point package
// Shared widths, constants, register indexes and stage payload types.
// ----------------------------------------------------------------------------
package hcp_pkg;

   // Field widths.
   localparam int IDX_W     = 12;
   localparam int STEP_W    = 17;
   localparam int T_W       = 17;
   localparam int COORD_W   = 16;
   localparam int PACK_W    = 48;
   localparam int OUT_W     = 18;

   // Internal arithmetic widths.
   localparam int TPROD_W   = IDX_W + STEP_W;
   localparam int SQ_W      = 2 * T_W;
   localparam int H_W       = 20;
   localparam int PROD_W    = H_W + COORD_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int FRAC_W    = 16;
   localparam int SHIFT_W   = SUM_W - FRAC_W;

   // Configuration port widths.
   localparam int APB_DATA_W = 64;
   localparam int APB_ADDR_W = 6;

   // Number of register stages from input to output.
   localparam int PIPE_DEPTH = 6;

   // One in Q1.16.
   localparam logic [T_W-1:0] ONE_Q16 = 17'd65536;

   // Output saturation bounds.
   localparam logic signed [SHIFT_W-1:0] OUT_MAX = 22'sd131071;
   localparam logic signed [SHIFT_W-1:0] OUT_MIN = -22'sd131072;

   // Register reset values.
   localparam logic [PACK_W-1:0] START_POINT_RESET   = 48'h0000_0100_0000;
   localparam logic [PACK_W-1:0] END_POINT_RESET     = 48'h0000_0000_0300;
   localparam logic [PACK_W-1:0] START_TANGENT_RESET = 48'h0000_0100_0000;
   localparam logic [PACK_W-1:0] END_TANGENT_RESET   = 48'h0000_0000_FD00;
   localparam logic [STEP_W-1:0] STEP_SIZE_RESET     = 17'd662;

   // Register indexes, taken from the word address.
   typedef enum logic [2:0] {
      REG_START_POINT   = 3'd0,
      REG_END_POINT     = 3'd1,
      REG_START_TANGENT = 3'd2,
      REG_END_TANGENT   = 3'd3,
      REG_STEP_SIZE     = 3'd4
   } reg_index_type;

   // Register file contents as seen by the datapath.
   typedef struct packed {
      logic [PACK_W-1:0] start_point;
      logic [PACK_W-1:0] end_point;
      logic [PACK_W-1:0] start_tangent;
      logic [PACK_W-1:0] end_tangent;
      logic [STEP_W-1:0] step_size;
   } csr_type;

   // Hermite basis weights, signed Q.16.
   typedef struct packed {
      logic signed [H_W-1:0] h00;
      logic signed [H_W-1:0] h01;
      logic signed [H_W-1:0] h10;
      logic signed [H_W-1:0] h11;
   } weights_type;

   // Handshake between the basis stages and the blend stages.
   typedef struct packed {
      logic        valid;
      weights_type weights;
   } basis_word_type;

endpackage : hcp_pkg
`default_nettype wire

@@ rtl/hcp_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one sample index per word.
// ----------------------------------------------------------------------------
interface hcp_req_if;
   logic                        valid;
   logic                        ready;
   logic [hcp_pkg::IDX_W-1:0]   sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink   (input valid, input sample_index, output ready);
endinterface : hcp_req_if
`default_nettype wire

@@ rtl/hcp_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Curve point response channel
// Valid/ready channel that carries one 3-D curve point per word.
// ----------------------------------------------------------------------------
interface hcp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [hcp_pkg::OUT_W-1:0]  point_x;
   logic signed [hcp_pkg::OUT_W-1:0]  point_y;
   logic signed [hcp_pkg::OUT_W-1:0]  point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface : hcp_rsp_if
`default_nettype wire

@@ rtl/cubic_hermite_curve_point.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite curve point evaluator
// Evaluates a 3-D cubic Hermite curve at one sample index per word.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one sample index per word; the rsp channel returns
//   one Q10.8 point (x, y, z) per request, in order. Control points, tangents
//   and the Q1.16 step are set through the APB-style port; write them only
//   while no word is in flight.
// Pipeline: an accepted request passes through six register stages, one
//   each for t, t squared, t cubed, the basis weights, the weight products
//   and the summed, clamped output.
// Throughput: one word per cycle while rsp is ready. Every stage has its own
//   valid bit and moves whenever it is empty or the stage after it moves, so
//   bubbles close up and req stays ready while a result waits on rsp.
// Stalls: when rsp is not taken the words back up stage by stage; req.ready
//   drops only once all six stages hold a word. Nothing is lost or repeated.
// Reset: synchronous; it empties the pipeline and restores the register
//   defaults, a curve from (0,1,0) to (3,0,0) with step 662.
// ----------------------------------------------------------------------------
module cubic_hermite_curve_point (
   input  wire logic                              clock,
   input  wire logic                              reset,
   hcp_req_if.sink                                req,
   hcp_rsp_if.source                              rsp,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [hcp_pkg::APB_ADDR_W-1:0]    paddr,
   input  wire logic [hcp_pkg::APB_DATA_W-1:0]    pwdata,
   output logic      [hcp_pkg::APB_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   hcp_pkg::csr_type        csr;
   hcp_pkg::basis_word_type basis_word;
   logic                    blend_ready;

   // Register file.
   hcp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   // Parameter and basis weight stages.
   hcp_basis u_basis (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .step_size  (csr.step_size),
      .down       (basis_word),
      .down_ready (blend_ready)
   );

   // Product and sum stages.
   hcp_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .up       (basis_word),
      .up_ready (blend_ready),
      .rsp      (rsp)
   );

endmodule : cubic_hermite_curve_point
`default_nettype wire

@@ rtl/hcp_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite curve point registers
// APB-style register file holding the control points, tangents and step.
// ----------------------------------------------------------------------------
module hcp_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [hcp_pkg::APB_ADDR_W-1:0]    paddr,
   input  wire logic [hcp_pkg::APB_DATA_W-1:0]    pwdata,
   output logic      [hcp_pkg::APB_DATA_W-1:0]    prdata,
   output logic                                   pready,
   output hcp_pkg::csr_type                       csr
);

   hcp_pkg::csr_type       csr_ff;
   hcp_pkg::csr_type       csr_in;
   hcp_pkg::reg_index_type reg_index;
   logic                   write_strobe;

   // Registers sit on 8-byte boundaries.
   assign reg_index    = hcp_pkg::reg_index_type'(paddr[5:3]);
   assign write_strobe = psel && penable && pwrite;
   assign pready       = 1'b1;

   // Next register contents for a write; unused indexes are dropped.
   always_comb begin
      csr_in = csr_ff;
      if (write_strobe) begin
         unique case (reg_index)
            hcp_pkg::REG_START_POINT:   csr_in.start_point   = pwdata[hcp_pkg::PACK_W-1:0];
            hcp_pkg::REG_END_POINT:     csr_in.end_point     = pwdata[hcp_pkg::PACK_W-1:0];
            hcp_pkg::REG_START_TANGENT: csr_in.start_tangent = pwdata[hcp_pkg::PACK_W-1:0];
            hcp_pkg::REG_END_TANGENT:   csr_in.end_tangent   = pwdata[hcp_pkg::PACK_W-1:0];
            hcp_pkg::REG_STEP_SIZE:     csr_in.step_size     = pwdata[hcp_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_point   <= hcp_pkg::START_POINT_RESET;
         csr_ff.end_point     <= hcp_pkg::END_POINT_RESET;
         csr_ff.start_tangent <= hcp_pkg::START_TANGENT_RESET;
         csr_ff.end_tangent   <= hcp_pkg::END_TANGENT_RESET;
         csr_ff.step_size     <= hcp_pkg::STEP_SIZE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Read mux.
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         hcp_pkg::REG_START_POINT:   prdata = 64'(csr_ff.start_point);
         hcp_pkg::REG_END_POINT:     prdata = 64'(csr_ff.end_point);
         hcp_pkg::REG_START_TANGENT: prdata = 64'(csr_ff.start_tangent);
         hcp_pkg::REG_END_TANGENT:   prdata = 64'(csr_ff.end_tangent);
         hcp_pkg::REG_STEP_SIZE:     prdata = 64'(csr_ff.step_size);
         default:                    prdata = '0;
      endcase
   end

   assign csr = csr_ff;

endmodule : hcp_csr
`default_nettype wire

@@ rtl/hcp_basis.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite basis stages
// Four pipeline stages: t from the index, t squared, t cubed, basis weights.
// ----------------------------------------------------------------------------
module hcp_basis (
   input  wire logic                          clock,
   input  wire logic                          reset,
   hcp_req_if.sink                            req,
   input  wire logic [hcp_pkg::STEP_W-1:0]    step_size,
   output hcp_pkg::basis_word_type            down,
   input  wire logic                          down_ready
);

   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic                        en1, en2, en3, en4;
   logic [hcp_pkg::T_W-1:0]     t1_ff, t1_in;
   logic [hcp_pkg::T_W-1:0]     t2_t_ff, t2_sq_ff, t2_sq_in;
   logic [hcp_pkg::T_W-1:0]     t3_t_ff, t3_sq_ff, t3_cu_ff, t3_cu_in;
   logic [hcp_pkg::TPROD_W-1:0] t_prod;
   logic [hcp_pkg::SQ_W-1:0]    sq_prod;
   logic [hcp_pkg::SQ_W-1:0]    cu_prod;
   hcp_pkg::weights_type        w_ff, w_in;
   logic signed [hcp_pkg::H_W-1:0] te, t2e, t3e;

   // A stage moves when it is empty or the stage after it moves.
   assign en4       = !v4_ff || down_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req.ready = en1;

   // Stage 1: t = index * step, held at one.
   assign t_prod = hcp_pkg::TPROD_W'(req.sample_index) * hcp_pkg::TPROD_W'(step_size);
   assign t1_in  = (t_prod > hcp_pkg::TPROD_W'(hcp_pkg::ONE_Q16)) ? hcp_pkg::ONE_Q16
                                                                   : t_prod[hcp_pkg::T_W-1:0];

   // Stage 2: t squared, low fraction bits dropped.
   assign sq_prod  = hcp_pkg::SQ_W'(t1_ff) * hcp_pkg::SQ_W'(t1_ff);
   assign t2_sq_in = sq_prod[hcp_pkg::FRAC_W +: hcp_pkg::T_W];

   // Stage 3: t cubed from t squared.
   assign cu_prod  = hcp_pkg::SQ_W'(t2_sq_ff) * hcp_pkg::SQ_W'(t2_t_ff);
   assign t3_cu_in = cu_prod[hcp_pkg::FRAC_W +: hcp_pkg::T_W];

   // Stage 4: the four basis weights.
   assign te  = $signed({3'b000, t3_t_ff});
   assign t2e = $signed({3'b000, t3_sq_ff});
   assign t3e = $signed({3'b000, t3_cu_ff});

   always_comb begin
      w_in.h00 = (t3e <<< 1) - (t2e <<< 1) - t2e
                 + $signed({3'b000, hcp_pkg::ONE_Q16});
      w_in.h01 = (t2e <<< 1) + t2e - (t3e <<< 1);
      w_in.h10 = t3e - (t2e <<< 1) + te;
      w_in.h11 = t3e - t2e;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Payload registers, loaded only with a live word.
   always_ff @(posedge clock) begin
      if (en1 && req.valid) begin
         t1_ff <= t1_in;
      end
      if (en2 && v1_ff) begin
         t2_t_ff  <= t1_ff;
         t2_sq_ff <= t2_sq_in;
      end
      if (en3 && v2_ff) begin
         t3_t_ff  <= t2_t_ff;
         t3_sq_ff <= t2_sq_ff;
         t3_cu_ff <= t3_cu_in;
      end
      if (en4 && v3_ff) begin
         w_ff <= w_in;
      end
   end

   assign down.valid   = v4_ff;
   assign down.weights = w_ff;

endmodule : hcp_basis
`default_nettype wire

@@ rtl/hcp_blend.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite blend stages
// Weight-times-coordinate products, then the per-axis sum, floor and clamp.
// ----------------------------------------------------------------------------
module hcp_blend (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hcp_pkg::csr_type      csr,
   input  wire hcp_pkg::basis_word_type up,
   output logic                       up_ready,
   hcp_rsp_if.source                  rsp
);

   logic                                 v5_ff, v6_ff;
   logic                                 en5, en6;
   logic [hcp_pkg::PACK_W-1:0]           packs [4];
   logic signed [hcp_pkg::H_W-1:0]       weights [4];
   logic signed [hcp_pkg::PROD_W-1:0]    prod_ff [3][4];
   logic signed [hcp_pkg::PROD_W-1:0]    prod_in [3][4];
   logic signed [hcp_pkg::OUT_W-1:0]     point_ff [3];
   logic signed [hcp_pkg::OUT_W-1:0]     point_in [3];

   // Output register frees when taken; stage 5 moves if empty or passing on.
   assign en6      = !v6_ff || rsp.ready;
   assign en5      = !v5_ff || en6;
   assign up_ready = en5;

   assign packs[0]   = csr.start_point;
   assign packs[1]   = csr.end_point;
   assign packs[2]   = csr.start_tangent;
   assign packs[3]   = csr.end_tangent;
   assign weights[0] = up.weights.h00;
   assign weights[1] = up.weights.h01;
   assign weights[2] = up.weights.h10;
   assign weights[3] = up.weights.h11;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [hcp_pkg::SUM_W-1:0]   sum;
      logic signed [hcp_pkg::SHIFT_W-1:0] floored;

      // Stage 5: one product per basis term.
      for (genvar k = 0; k < 4; k++) begin : g_term
         logic signed [hcp_pkg::COORD_W-1:0] coord;
         assign coord = $signed(packs[k][a*hcp_pkg::COORD_W +: hcp_pkg::COORD_W]);
         assign prod_in[a][k] = hcp_pkg::PROD_W'(weights[k]) * hcp_pkg::PROD_W'(coord);
      end

      // Stage 6: sum, drop the fraction toward minus infinity, clamp.
      assign sum = $signed({{2{prod_ff[a][0][hcp_pkg::PROD_W-1]}}, prod_ff[a][0]})
                 + $signed({{2{prod_ff[a][1][hcp_pkg::PROD_W-1]}}, prod_ff[a][1]})
                 + $signed({{2{prod_ff[a][2][hcp_pkg::PROD_W-1]}}, prod_ff[a][2]})
                 + $signed({{2{prod_ff[a][3][hcp_pkg::PROD_W-1]}}, prod_ff[a][3]});
      assign floored = sum[hcp_pkg::SUM_W-1:hcp_pkg::FRAC_W];

      always_comb begin
         priority if (floored > hcp_pkg::OUT_MAX) begin
            point_in[a] = hcp_pkg::OUT_MAX[hcp_pkg::OUT_W-1:0];
         end else if (floored < hcp_pkg::OUT_MIN) begin
            point_in[a] = hcp_pkg::OUT_MIN[hcp_pkg::OUT_W-1:0];
         end else begin
            point_in[a] = floored[hcp_pkg::OUT_W-1:0];
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en5) v5_ff <= up.valid;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en5 && up.valid) begin
         prod_ff <= prod_in;
      end
      if (en6 && v5_ff) begin
         point_ff <= point_in;
      end
   end

   assign rsp.valid   = v6_ff;
   assign rsp.point_x = point_ff[0];
   assign rsp.point_y = point_ff[1];
   assign rsp.point_z = point_ff[2];

endmodule : hcp_blend
`default_nettype wire

@@ rtl/hcp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite curve point checker
// Port-level assertions on result counting, occupancy, reset and output holding.
// ----------------------------------------------------------------------------
module hcp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic signed [hcp_pkg::OUT_W-1:0] point_x,
   input wire logic signed [hcp_pkg::OUT_W-1:0] point_y,
   input wire logic signed [hcp_pkg::OUT_W-1:0] point_z
);

   logic [2:0] count_ff, count_in;
   logic       in_fire, out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;

   // Words accepted but not yet delivered.
   always_comb begin
      count_in = count_ff;
      if (in_fire && !out_fire) count_in = count_ff + 3'd1;
      if (!in_fire && out_fire) count_in = count_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A result is only delivered for a word that went in.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      out_fire |-> (count_ff != 3'd0))
      else $error("result delivered with no word in flight");

   // The pipeline never holds more words than it has stages.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(hcp_pkg::PIPE_DEPTH))
      else $error("more words in flight than pipeline stages");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(point_x) && $stable(point_y) && $stable(point_z)))
      else $error("stalled result changed or dropped");

endmodule : hcp_checker

bind cubic_hermite_curve_point hcp_checker u_hcp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .point_x   (rsp.point_x),
   .point_y   (rsp.point_y),
   .point_z   (rsp.point_z)
);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic Hermite curve point testbench
// Streams sample indexes into the evaluator under a number of curve and step
// settings, predicts every curve point in fixed point, and checks each
// returned word in order against the prediction, with random gaps and stalls
// on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 5;
   localparam int REG_STRIDE     = 8;
   localparam int SPARE_REG_LO   = 5;
   localparam int SPARE_REG_HI   = 7;
   localparam int SEGMENTS       = 7;
   localparam int SEGMENT_ITEMS  = 250;
   localparam int REPORT_LIMIT   = 10;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int Q16_ONE        = 65536;
   localparam int STEP_MAX       = 131071;
   localparam int IDX_MAX        = 4095;

   typedef struct packed {
      logic signed [hcp_pkg::OUT_W-1:0] x;
      logic signed [hcp_pkg::OUT_W-1:0] y;
      logic signed [hcp_pkg::OUT_W-1:0] z;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [hcp_pkg::APB_ADDR_W-1:0] paddr = '0;
   logic [hcp_pkg::APB_DATA_W-1:0] pwdata = '0;
   logic [hcp_pkg::APB_DATA_W-1:0] prdata;
   logic pready;

   hcp_req_if req_ch ();
   hcp_rsp_if rsp_ch ();

   cubic_hermite_curve_point dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Local copy of the curve registers, as the block holds them.
   logic [hcp_pkg::PACK_W-1:0] curve_p0 = hcp_pkg::START_POINT_RESET;
   logic [hcp_pkg::PACK_W-1:0] curve_p1 = hcp_pkg::END_POINT_RESET;
   logic [hcp_pkg::PACK_W-1:0] curve_d0 = hcp_pkg::START_TANGENT_RESET;
   logic [hcp_pkg::PACK_W-1:0] curve_d1 = hcp_pkg::END_TANGENT_RESET;
   logic [hcp_pkg::STEP_W-1:0] curve_step = hcp_pkg::STEP_SIZE_RESET;

   logic [hcp_pkg::IDX_W-1:0] pending_samples[$];
   point_type        curve_points[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               samples_issued = 0;
   int               samples_taken = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   logic             req_taken = 1'b0;

   always #CLOCK_HALF clock = ~clock;

   // Curve point at one sample index under the current registers.
   function automatic point_type hermite_point(input logic [hcp_pkg::IDX_W-1:0] idx);
      longint t, t2, t3, h00, h01, h10, h11, acc, r;
      logic signed [hcp_pkg::COORD_W-1:0] p0, p1, d0, d1;
      logic signed [hcp_pkg::OUT_W-1:0] coord[3];
      point_type pt;
      t = longint'(idx) * longint'(curve_step);
      if (t > Q16_ONE) begin
         t = Q16_ONE;
      end
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      h00 = 2 * t3 - 3 * t2 + Q16_ONE;
      h01 = -2 * t3 + 3 * t2;
      h10 = t3 - 2 * t2 + t;
      h11 = t3 - t2;
      for (int a = 0; a < 3; a++) begin
         p0 = curve_p0[16*a +: 16];
         p1 = curve_p1[16*a +: 16];
         d0 = curve_d0[16*a +: 16];
         d1 = curve_d1[16*a +: 16];
         acc = h00 * p0 + h01 * p1 + h10 * d0 + h11 * d1;
         // Floor division by 2^16, then clamp to the Q10.8 range.
         r = acc >>> 16;
         if (r > 131071) begin
            r = 131071;
         end
         if (r < -131072) begin
            r = -131072;
         end
         coord[a] = r[hcp_pkg::OUT_W-1:0];
      end
      pt.x = coord[0];
      pt.y = coord[1];
      pt.z = coord[2];
      return pt;
   endfunction

   task automatic note_mismatch(input string what, input point_type want,
                                input point_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)", $realtime,
                  what, want.x, want.y, want.z, got.x, got.y, got.z);
      end
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input int index, input logic [hcp_pkg::APB_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= hcp_pkg::APB_ADDR_W'(index * REG_STRIDE);
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         hcp_pkg::REG_START_POINT:   curve_p0 = value[hcp_pkg::PACK_W-1:0];
         hcp_pkg::REG_END_POINT:     curve_p1 = value[hcp_pkg::PACK_W-1:0];
         hcp_pkg::REG_START_TANGENT: curve_d0 = value[hcp_pkg::PACK_W-1:0];
         hcp_pkg::REG_END_TANGENT:   curve_d1 = value[hcp_pkg::PACK_W-1:0];
         hcp_pkg::REG_STEP_SIZE:     curve_step = value[hcp_pkg::STEP_W-1:0];
         default: ;
      endcase
   endtask

   // Loads a whole curve; the upper data bits carry junk the block must drop.
   task automatic load_curve(input logic [hcp_pkg::PACK_W-1:0] p0,
                             input logic [hcp_pkg::PACK_W-1:0] p1,
                             input logic [hcp_pkg::PACK_W-1:0] d0,
                             input logic [hcp_pkg::PACK_W-1:0] d1,
                             input logic [hcp_pkg::STEP_W-1:0] step);
      csr_write(hcp_pkg::REG_START_POINT, {16'($urandom), p0});
      csr_write(hcp_pkg::REG_END_POINT, {16'($urandom), p1});
      csr_write(hcp_pkg::REG_START_TANGENT, {16'($urandom), d0});
      csr_write(hcp_pkg::REG_END_TANGENT, {16'($urandom), d1});
      csr_write(hcp_pkg::REG_STEP_SIZE, {47'($urandom), step});
   endtask

   task automatic queue_sample(input int idx);
      pending_samples.push_back(hcp_pkg::IDX_W'(idx));
      samples_issued++;
   endtask

   // Wait until every word has been taken and answered, then let the pipe settle.
   task automatic drain();
      while (samples_taken != samples_issued || curve_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (hcp_pkg::PIPE_DEPTH + 2) @(posedge clock);
   endtask

   // Random packed point, with the coordinate extremes favored.
   function automatic logic [hcp_pkg::PACK_W-1:0] random_pack();
      logic [hcp_pkg::PACK_W-1:0] p;
      for (int a = 0; a < 3; a++) begin
         case ($urandom_range(7))
            0: p[16*a +: 16] = 16'h7FFF;
            1: p[16*a +: 16] = 16'h8000;
            2: p[16*a +: 16] = 16'h0000;
            default: p[16*a +: 16] = 16'($urandom);
         endcase
      end
      return p;
   endfunction

   function automatic logic [hcp_pkg::STEP_W-1:0] random_step();
      int n;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: return '0;
               1: return hcp_pkg::STEP_W'(1);
               2: return hcp_pkg::STEP_W'(Q16_ONE);
               default: return hcp_pkg::STEP_W'(STEP_MAX);
            endcase
         end
         1, 2: return hcp_pkg::STEP_W'($urandom_range(STEP_MAX));
         default: begin
            // Step of a real tessellation: 1 / (sample count - 1).
            n = $urandom_range(IDX_MAX + 1, 2);
            return hcp_pkg::STEP_W'(Q16_ONE / (n - 1));
         end
      endcase
   endfunction

   // Sender: holds a word until it is taken, then offers the next or idles.
   always @(negedge clock) begin
      if (!req_ch.valid || req_taken) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.sample_index <= pending_samples.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: predicts on every accepted request, checks every accepted point.
   always @(posedge clock) begin
      point_type got;
      point_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
         got.x = rsp_ch.point_x;
         got.y = rsp_ch.point_y;
         got.z = rsp_ch.point_z;
         if (curve_points.size() == 0) begin
            note_mismatch("point with no request", '0, got);
         end else begin
            want = curve_points.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
               note_mismatch("point mismatch", want, got);
            end
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         curve_points.push_back(hermite_point(req_ch.sample_index));
         samples_taken++;
      end
   end

   // Stimulus sequence.
   initial begin
      int limit;
      int corner_idx[8] = '{0, 1, 50, 98, 99, 100, 2048, IDX_MAX};
      req_ch.valid = 1'b0;
      req_ch.sample_index = '0;
      rsp_ch.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default curve: ends of the range, the last in-range index and beyond.
      send_idle_pct = 17;
      recv_idle_pct = 73;
      foreach (corner_idx[i]) begin
         queue_sample(corner_idx[i]);
      end
      drain();

      // Largest coordinates, a step of exactly one: t is 0, 1, then held at one.
      // Writes to unused register slots must not disturb anything.
      load_curve({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}},
                 hcp_pkg::STEP_W'(Q16_ONE));
      for (int i = SPARE_REG_LO; i <= SPARE_REG_HI; i++) begin
         csr_write(i, {$urandom, $urandom});
      end
      queue_sample(0);
      queue_sample(1);
      queue_sample(2);
      drain();

      // Step above one, most negative start point and start tangent.
      load_curve({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}},
                 hcp_pkg::STEP_W'(STEP_MAX));
      queue_sample(0);
      queue_sample(1);
      queue_sample(IDX_MAX);
      drain();

      // Zero step keeps t at zero; a step of one keeps t tiny, so the truncated
      // square vanishes at index 255 but not at 256 or 4095.
      load_curve({16'h1234, 16'hF00D, 16'h8001}, {16'h7FFE, 16'h0001, 16'hFFFF},
                 {16'hC000, 16'h4000, 16'h0100}, {16'h00FF, 16'hFF01, 16'h8000}, '0);
      queue_sample(IDX_MAX);
      queue_sample(1);
      drain();
      csr_write(hcp_pkg::REG_STEP_SIZE, hcp_pkg::STEP_W'(1));
      queue_sample(IDX_MAX);
      queue_sample(255);
      queue_sample(256);
      drain();

      // Random curves; indexes mostly span the useful range of the step.
      for (int s = 0; s < SEGMENTS; s++) begin
         if (s < 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 73;
         end else if (s < 5) begin
            send_idle_pct = 73;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_curve(random_pack(), random_pack(), random_pack(), random_pack(),
                    random_step());
         limit = (curve_step == 0) ? IDX_MAX : Q16_ONE / curve_step + 2;
         if (limit > IDX_MAX) begin
            limit = IDX_MAX;
         end
         @(posedge clock);
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            if ($urandom_range(99) < 85) begin
               queue_sample($urandom_range(limit));
            end else begin
               queue_sample($urandom_range(IDX_MAX));
            end
         end
         drain();
      end

      repeat (hcp_pkg::PIPE_DEPTH * 2) @(posedge clock);
      if (mismatch_count == 0 && curve_points.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule : tb
